// ===== sv/mwo_pkg.sv =====
// Shared types, register indexes, defaults and the cosine table generator of the oscillator.
`timescale 1ns / 1ps

package mwo_pkg;

  // Default sizes handed down from the top level.
  localparam int unsigned PhaseBitsDef     = 32;
  localparam int unsigned SineTableBitsDef = 10;

  // Fixed field widths.
  localparam int unsigned IndexW  = 32;
  localparam int unsigned StepW   = 32;
  localparam int unsigned AmpW    = 15;
  localparam int unsigned DutyW   = 16;
  localparam int unsigned SelW    = 3;
  localparam int unsigned SampleW = 16;
  localparam int unsigned FracW   = 32;
  localparam int unsigned CosW    = 17;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned CfgAddrW = 2;

  // Register values after reset.
  localparam logic [SelW-1:0]  SelRst  = 3'd0;
  localparam logic [StepW-1:0] StepRst = 32'd39370534;
  localparam logic [AmpW-1:0]  AmpRst  = 15'd16384;
  localparam logic [DutyW-1:0] DutyRst = 16'd32768;

  // Quarter of a period in Q30 radians.
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // Waveform codes; codes above the pulse give silence.
  typedef enum logic [SelW-1:0] {
    WAVE_COSINE   = 3'd0,
    WAVE_SQUARE   = 3'd1,
    WAVE_SAWTOOTH = 3'd2,
    WAVE_TRIANGLE = 3'd3,
    WAVE_PULSE    = 3'd4,
    WAVE_SILENT   = 3'd5
  } wave_e;

  // Configuration register indexes.
  typedef enum logic [CfgAddrW-1:0] {
    CFG_WAVE_SEL   = 2'd0,
    CFG_PHASE_STEP = 2'd1,
    CFG_AMPLITUDE  = 2'd2,
    CFG_PULSE_DUTY = 2'd3
  } cfg_idx_e;

  // Control that travels with a beat from the shaping stage to the scaling stage.
  typedef struct packed {
    logic  valid;
    wave_e wave;
    logic  neg;
  } shp_ctrl_t;

  // Cosine of entry k of a quarter-wave table, unsigned Q16, clamped to 65536.
  // Evaluated at elaboration only, a nine-term Taylor series in Q30.
  function automatic logic [CosW-1:0] cos_q16(input int unsigned k, input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      q;
    x    = (64'(k) * HalfPiQ30) >> tbits;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    term = ((term * x2) >> 30) / 64'd2;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd12;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd30;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd56;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd90;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd132;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd182;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd240;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      return '0;
    end
    q = (sum + 64'sd8192) >>> 14;
    if (q > 64'sd65536) begin
      q = 64'sd65536;
    end
    return CosW'(q);
  endfunction

endpackage

// ===== sv/mwo_phase.sv =====
// First pipeline stage: phase computed as sample index times phase step.
`timescale 1ns / 1ps

module mwo_phase #(
  parameter int unsigned PHASE_BITS = mwo_pkg::PhaseBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [mwo_pkg::IndexW-1:0]  index_i,
  input  logic [mwo_pkg::StepW-1:0]   step_i,
  output logic                        valid_o,
  output logic [PHASE_BITS-1:0]       phase_o
);
  import mwo_pkg::*;

  logic [IndexW+StepW-1:0] prod;
  logic                    valid_q;
  logic [PHASE_BITS-1:0]   phase_d;
  logic [PHASE_BITS-1:0]   phase_q;

  // One 32 by 32 product; the phase wraps at the phase width.
  assign prod    = index_i * step_i;
  assign phase_d = prod[PHASE_BITS-1:0];

  // Valid bit for the beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Phase register, payload only.
  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;
  end

  assign valid_o = valid_q;
  assign phase_o = phase_q;

endmodule

// ===== sv/mwo_shape.sv =====
// Second pipeline stage: phase to 32-bit fraction, waveform shaping and cosine table lookup.
`timescale 1ns / 1ps

module mwo_shape #(
  parameter int unsigned PHASE_BITS      = mwo_pkg::PhaseBitsDef,
  parameter int unsigned SINE_TABLE_BITS = mwo_pkg::SineTableBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [PHASE_BITS-1:0]      phase_i,
  input  logic [mwo_pkg::SelW-1:0]   wave_sel_i,
  input  logic [mwo_pkg::DutyW-1:0]  duty_i,
  output mwo_pkg::shp_ctrl_t         ctrl_o,
  output logic [mwo_pkg::FracW-1:0]  operand_o,
  output logic [mwo_pkg::CosW-1:0]   cos_o
);
  import mwo_pkg::*;

  localparam int unsigned TabN  = 1 << SINE_TABLE_BITS;
  localparam int unsigned AddrW = SINE_TABLE_BITS + 1;

  typedef logic [CosW-1:0] rom_t [TabN+1];

  // Quarter-wave cosine table, worked out at elaboration.
  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k <= int'(TabN); k++) begin
      r[k] = cos_q16(k, SINE_TABLE_BITS);
    end
    return r;
  endfunction

  localparam rom_t Rom = build_rom();

  logic [FracW-1:0]           u;
  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-1:0] tab_idx;
  logic [AddrW-1:0]           addr;
  logic [FracW-1:0]           half_dist;
  wave_e                      wave;
  logic                       neg_d;
  logic [FracW-1:0]           operand_d;
  logic                       valid_q;
  wave_e                      wave_q;
  logic                       neg_q;
  logic [FracW-1:0]           operand_q;
  logic [CosW-1:0]            rom_q;

  // Bring the phase to a 32-bit fraction of a period.
  if (PHASE_BITS >= FracW) begin : g_frac_down
    assign u = phase_i[PHASE_BITS-1 -: FracW];
  end else begin : g_frac_up
    assign u = {phase_i, {(FracW-PHASE_BITS){1'b0}}};
  end

  // Table address: odd quadrants read the table mirrored.
  assign quad    = u[FracW-1 -: 2];
  assign tab_idx = u[FracW-3 -: SINE_TABLE_BITS];
  assign addr    = quad[0] ? (AddrW'(TabN) - AddrW'(tab_idx)) : AddrW'(tab_idx);

  // Distance of the phase from one half.
  assign half_dist = u[FracW-1] ? {1'b0, u[FracW-2:0]} : (32'h8000_0000 - u);
  assign wave      = wave_e'(wave_sel_i);

  // Sign and multiplier operand for each waveform.
  always_comb begin
    neg_d     = 1'b0;
    operand_d = '0;
    case (wave) inside
      WAVE_COSINE: begin
        neg_d = (quad == 2'd1) || (quad == 2'd2);
      end
      WAVE_SQUARE: begin
        neg_d = !((u != '0) && !u[FracW-1]);
      end
      WAVE_SAWTOOTH: begin
        neg_d     = !u[FracW-1];
        operand_d = half_dist;
      end
      WAVE_TRIANGLE: begin
        neg_d     = 1'b1;
        operand_d = 32'h8000_0000 - half_dist;
      end
      WAVE_PULSE: begin
        neg_d = !(u[FracW-1 -: DutyW] < duty_i);
      end
      default: begin
        neg_d     = 1'b0;
        operand_d = '0;
      end
    endcase
  end

  // Valid bit for the beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Payload registers and the registered table read.
  always_ff @(posedge clk_i) begin
    wave_q    <= wave;
    neg_q     <= neg_d;
    operand_q <= operand_d;
    rom_q     <= Rom[addr];
  end

  assign ctrl_o    = '{valid: valid_q, wave: wave_q, neg: neg_q};
  assign operand_o = operand_q;
  assign cos_o     = rom_q;

endmodule

// ===== sv/mwo_scale.sv =====
// Third and fourth pipeline stages: amplitude scaling, then sign and the output register.
`timescale 1ns / 1ps

module mwo_scale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mwo_pkg::shp_ctrl_t            ctrl_i,
  input  logic [mwo_pkg::FracW-1:0]     operand_i,
  input  logic [mwo_pkg::CosW-1:0]      cos_i,
  input  logic [mwo_pkg::AmpW-1:0]      amp_i,
  output logic                          strobe_o,
  output logic signed [mwo_pkg::SampleW-1:0] sample_o
);
  import mwo_pkg::*;

  localparam int unsigned ProdW = FracW + AmpW;

  logic [FracW-1:0]   mul_a;
  logic [ProdW-1:0]   prod;
  logic [AmpW-1:0]    mag_d;
  logic               valid3_q;
  logic               neg3_q;
  logic [AmpW-1:0]    mag_q;
  logic [SampleW-1:0] mag_ext;
  logic [SampleW-1:0] sample_d;
  logic               valid4_q;
  logic [SampleW-1:0] sample_q;

  // Cosine takes its magnitude from the table, the ramps from the shaping stage.
  assign mul_a = (ctrl_i.wave == WAVE_COSINE) ? FracW'(cos_i) : operand_i;
  assign prod  = ProdW'(mul_a) * ProdW'(amp_i);

  // Scale back to an amplitude-sized magnitude.
  always_comb begin
    case (ctrl_i.wave) inside
      WAVE_COSINE:                 mag_d = AmpW'(prod >> 16);
      WAVE_SAWTOOTH, WAVE_TRIANGLE: mag_d = AmpW'(prod >> 31);
      WAVE_SQUARE, WAVE_PULSE:     mag_d = amp_i;
      default:                     mag_d = '0;
    endcase
  end

  // Apply the sign to the scaled magnitude.
  assign mag_ext  = {1'b0, mag_q};
  assign sample_d = neg3_q ? (SampleW'(0) - mag_ext) : mag_ext;

  // Valid bits for stages three and four.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else begin
      valid3_q <= ctrl_i.valid;
      valid4_q <= valid3_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    neg3_q   <= ctrl_i.neg;
    mag_q    <= mag_d;
    sample_q <= sample_d;
  end

  assign strobe_o = valid4_q;
  assign sample_o = $signed(sample_q);

endmodule

// ===== sv/multi_waveform_oscillator.sv =====
// Top level of the multi-waveform oscillator: configuration registers and the four-stage pipeline.
`timescale 1ns / 1ps

// Multi-waveform oscillator.
// Input channel: a beat carries sample_index_i and is taken at a rising edge with start high
// and busy low. busy is always low, so a new index may be given in every cycle.
// Output channel: each beat appears on sample_value_o for exactly one cycle with strobe high.
// The receiver cannot stall, and none is needed: every beat leaves in order, one per input.
// Path: an index taken at an edge passes through the registered stages phase multiply,
// shaping and table read, amplitude multiply, and sign and output register, and then
// shows as its sample with strobe high.
// Throughput: one sample per clock cycle, set by the fully pipelined path with one table
// read port and two multipliers each used once per beat.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_addr_i at the edge; the
// registers are waveform select, phase step, amplitude and pulse duty. Change them only
// while no sample is in flight.
// Reset: the registers return to cosine, their default step, half scale amplitude and a
// half duty; the pipeline empties at once. The cosine table is constant and needs no fill.
module multi_waveform_oscillator #(
  parameter int unsigned PHASE_BITS      = mwo_pkg::PhaseBitsDef,
  parameter int unsigned SINE_TABLE_BITS = mwo_pkg::SineTableBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [mwo_pkg::IndexW-1:0]         sample_index_i,
  output logic                               strobe,
  output logic signed [mwo_pkg::SampleW-1:0] sample_value_o,
  input  logic                               cfg_we_i,
  input  logic [mwo_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  logic [mwo_pkg::CfgW-1:0]           cfg_wdata_i
);
  import mwo_pkg::*;

  logic [SelW-1:0]       wave_sel_q;
  logic [StepW-1:0]      step_q;
  logic [AmpW-1:0]       amp_q;
  logic [DutyW-1:0]      duty_q;
  logic                  accept;
  logic                  phase_vld;
  logic [PHASE_BITS-1:0] phase;
  shp_ctrl_t             shp_ctrl;
  logic [FracW-1:0]      shp_operand;
  logic [CosW-1:0]       shp_cos;

  // The pipeline takes a beat in every cycle.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_sel_q <= SelRst;
      step_q     <= StepRst;
      amp_q      <= AmpRst;
      duty_q     <= DutyRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_WAVE_SEL:   wave_sel_q <= cfg_wdata_i[SelW-1:0];
        CFG_PHASE_STEP: step_q     <= cfg_wdata_i[StepW-1:0];
        CFG_AMPLITUDE:  amp_q      <= cfg_wdata_i[AmpW-1:0];
        CFG_PULSE_DUTY: duty_q     <= cfg_wdata_i[DutyW-1:0];
        default: ;
      endcase
    end
  end

  // Stage one: phase.
  mwo_phase #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .index_i (sample_index_i),
    .step_i  (step_q),
    .valid_o (phase_vld),
    .phase_o (phase)
  );

  // Stage two: waveform shaping and table read.
  mwo_shape #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_shape (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (phase_vld),
    .phase_i    (phase),
    .wave_sel_i (wave_sel_q),
    .duty_i     (duty_q),
    .ctrl_o     (shp_ctrl),
    .operand_o  (shp_operand),
    .cos_o      (shp_cos)
  );

  // Stages three and four: scaling and sign.
  mwo_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (shp_ctrl),
    .operand_i (shp_operand),
    .cos_i     (shp_cos),
    .amp_i     (amp_q),
    .strobe_o  (strobe),
    .sample_o  (sample_value_o)
  );

  // Every accepted beat comes out on strobe.
  a_accept_to_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 strobe)
    else $error("accepted index gave no sample four cycles later");

  // No sample appears without an accepted index behind it.
  a_strobe_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> $past(accept, 4))
    else $error("sample strobe without a matching accepted index");

  // Silent selections give zero.
  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe && (wave_sel_q > SelW'(WAVE_PULSE))) |-> (sample_value_o == '0))
    else $error("silent waveform produced a non-zero sample");

  // The sample never exceeds the configured amplitude in magnitude.
  a_within_amp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> (($signed({sample_value_o[SampleW-1], sample_value_o})
                 <= $signed({2'b00, amp_q})) &&
                ($signed({sample_value_o[SampleW-1], sample_value_o})
                 >= -$signed({2'b00, amp_q}))))
    else $error("sample magnitude above the amplitude setting");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench of the multi-waveform oscillator: a directed table, then random phases.
`timescale 1ns / 1ps

module tb;
  import mwo_pkg::*;

  localparam int unsigned TabBits     = SineTableBitsDef;
  localparam int unsigned TabN        = 1 << TabBits;
  localparam int unsigned NumDir      = 24;
  localparam int unsigned RandomBeats = 500;
  localparam int unsigned DrainCycles = 8;
  localparam logic [31:0] HalfTurn    = 32'h8000_0000;

  // Selection codes beyond the silent one; both must give silence as well.
  localparam logic [SelW-1:0] WaveSpareLo = 3'd6;
  localparam logic [SelW-1:0] WaveSpareHi = 3'd7;

  // One row of the directed table: raw register words, the index and, where obvious, the sample.
  typedef struct packed {
    logic [CfgW-1:0]           sel;
    logic [CfgW-1:0]           step;
    logic [CfgW-1:0]           amp;
    logic [CfgW-1:0]           duty;
    logic [IndexW-1:0]         index;
    bit                        known;
    logic signed [SampleW-1:0] value;
  } dir_row_t;

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         start          = 1'b0;
  logic                         busy;
  logic [IndexW-1:0]            sample_index_i = '0;
  logic                         strobe;
  logic signed [SampleW-1:0]    sample_value_o;
  logic                         cfg_we_i       = 1'b0;
  logic [CfgAddrW-1:0]          cfg_addr_i     = CFG_WAVE_SEL;
  logic [CfgW-1:0]              cfg_wdata_i    = '0;

  // Shadow copy of the registers and the quarter-wave cosine magnitudes.
  logic [SelW-1:0]              wave_r = SelRst;
  logic [StepW-1:0]             step_r = StepRst;
  logic [AmpW-1:0]              amp_r  = AmpRst;
  logic [DutyW-1:0]             duty_r = DutyRst;
  logic [CosW-1:0]              cos_mag [TabN+1];

  logic signed [SampleW-1:0]    expected_samples [$];
  logic signed [SampleW-1:0]    due_sample;
  int unsigned                  mismatches  = 0;
  int unsigned                  burst_left  = 0;
  bit                           gapless     = 1'b0;

  dir_row_t dir_rows [NumDir] = '{
    '{32'(WAVE_COSINE),   StepRst, 32'(AmpRst), 32'(DutyRst), 32'h0000_0000, 1'b1, 16'sd16384},
    '{32'(WAVE_COSINE),   StepRst, 32'(AmpRst), 32'(DutyRst), 32'h0000_0001, 1'b0, 16'sd0},
    '{32'(WAVE_COSINE),   32'h0,   32'h7FFF,    32'(DutyRst), 32'hFFFF_FFFF, 1'b1, 16'sd32767},
    '{32'(WAVE_COSINE),   '1,      '1,          32'(DutyRst), 32'hFFFF_FFFF, 1'b0, 16'sd0},
    '{32'(WAVE_COSINE),   32'h1,   32'h7FFF,    32'(DutyRst), 32'h4000_0000, 1'b0, 16'sd0},
    '{32'(WAVE_COSINE),   32'h1,   32'h7FFF,    32'(DutyRst), 32'h8000_0000, 1'b1, -16'sd32767},
    '{32'(WAVE_COSINE),   32'h1,   32'h7FFF,    32'(DutyRst), 32'hC000_0000, 1'b0, 16'sd0},
    '{32'(WAVE_COSINE),   32'h1,   32'h0,       32'(DutyRst), 32'h1234_5678, 1'b1, 16'sd0},
    '{32'(WAVE_SQUARE),   32'h1,   32'h7FFF,    32'(DutyRst), 32'h0000_0000, 1'b1, -16'sd32767},
    '{32'(WAVE_SQUARE),   32'h1,   32'h7FFF,    32'(DutyRst), 32'h0000_0001, 1'b1, 16'sd32767},
    '{32'(WAVE_SQUARE),   32'h1,   32'h7FFF,    32'(DutyRst), 32'h8000_0000, 1'b1, -16'sd32767},
    '{32'(WAVE_SAWTOOTH), 32'h1,   32'h7FFF,    32'(DutyRst), 32'h0000_0000, 1'b1, -16'sd32767},
    '{32'(WAVE_SAWTOOTH), 32'h1,   32'h7FFF,    32'(DutyRst), 32'h8000_0000, 1'b1, 16'sd0},
    '{32'(WAVE_SAWTOOTH), 32'h1,   32'h7FFF,    32'(DutyRst), 32'hFFFF_FFFF, 1'b0, 16'sd0},
    '{32'(WAVE_TRIANGLE), 32'h1,   32'h7FFF,    32'(DutyRst), 32'h0000_0000, 1'b1, 16'sd0},
    '{32'(WAVE_TRIANGLE), 32'h1,   32'h7FFF,    32'(DutyRst), 32'h8000_0000, 1'b1, -16'sd32767},
    '{32'(WAVE_TRIANGLE), 32'h1,   32'h7FFF,    32'(DutyRst), 32'h4000_0000, 1'b0, 16'sd0},
    '{32'(WAVE_PULSE),    32'h1,   32'h7FFF,    32'h0,        32'h0000_0000, 1'b1, -16'sd32767},
    '{32'(WAVE_PULSE),    32'h1,   32'h7FFF,    32'hFFFF,     32'hFFFE_FFFF, 1'b1, 16'sd32767},
    '{32'(WAVE_PULSE),    32'h1,   32'h7FFF,    32'hFFFF,     32'hFFFF_0000, 1'b1, -16'sd32767},
    '{32'(WAVE_PULSE),    32'h1,   32'h7FFF,    32'hFFFF_8000, 32'h7FFF_FFFF, 1'b1, 16'sd32767},
    '{{29'h1FFF_FFFF, WAVE_SILENT}, 32'h1, 32'h7FFF, 32'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'sd0},
    '{32'(WaveSpareLo),   32'h1,   32'h7FFF,    32'hFFFF,     32'h0000_0001, 1'b1, 16'sd0},
    '{32'(WaveSpareHi),   32'h1,   32'h7FFF,    32'hFFFF,     32'h0000_0001, 1'b1, 16'sd0}
  };

  multi_waveform_oscillator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .sample_index_i (sample_index_i),
    .strobe         (strobe),
    .sample_value_o (sample_value_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // Free-running clock.
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Sample expected for an index under the current register settings.
  function automatic logic signed [SampleW-1:0] predict_sample(logic [IndexW-1:0] idx);
    logic [63:0]     prod;
    logic [31:0]     u;
    logic [31:0]     offset;
    logic [1:0]      quad;
    int unsigned     ent;
    logic [CosW-1:0] mag;
    longint          amp;
    longint          level;
    prod   = 64'(idx) * 64'(step_r);
    u      = prod[31:0];
    amp    = longint'(amp_r);
    offset = (u < HalfTurn) ? HalfTurn - u : u - HalfTurn;
    level  = 0;
    case (wave_r)
      WAVE_COSINE: begin
        quad  = u[31:30];
        ent   = int'((u & 32'h3FFF_FFFF) >> (30 - TabBits));
        mag   = quad[0] ? cos_mag[TabN - ent] : cos_mag[ent];
        level = longint'((64'(amp_r) * 64'(mag)) >> 16);
        if (quad == 2'd1 || quad == 2'd2) begin
          level = -level;
        end
      end
      WAVE_SQUARE: begin
        level = (u != 0 && u < HalfTurn) ? amp : -amp;
      end
      WAVE_SAWTOOTH: begin
        level = longint'((64'(offset) * 64'(amp_r)) >> 31);
        if (u < HalfTurn) begin
          level = -level;
        end
      end
      WAVE_TRIANGLE: begin
        level = -longint'(((64'(HalfTurn) - 64'(offset)) * 64'(amp_r)) >> 31);
      end
      WAVE_PULSE: begin
        level = (64'(u) < (64'(duty_r) << 16)) ? amp : -amp;
      end
      default: begin
        level = 0;
      end
    endcase
    return level[SampleW-1:0];
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(string what);
    $display("tb: mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Sends one index beat, with random gaps between bursts unless gapless is set, and files its expected sample.
  task automatic send_index(logic [IndexW-1:0] idx, bit known, logic signed [SampleW-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = gapless ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    start          <= 1'b1;
    sample_index_i <= idx;
    do @(posedge clk_i); while (busy);
    expected_samples.push_back(known ? value : predict_sample(idx));
  endtask

  // Stops sending and waits until every filed sample has come back.
  task automatic wait_drained();
    start <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
  endtask

  // Writes one register and keeps the shadow copy, masked to its width.
  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] word);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= word;
    @(posedge clk_i);
    case (idx)
      CFG_WAVE_SEL:   wave_r = word[SelW-1:0];
      CFG_PHASE_STEP: step_r = word[StepW-1:0];
      CFG_AMPLITUDE:  amp_r  = word[AmpW-1:0];
      CFG_PULSE_DUTY: duty_r = word[DutyW-1:0];
      default: ;
    endcase
  endtask

  // Rewrites all four registers once the pipeline is empty.
  task automatic apply_settings(logic [CfgW-1:0] sel_w, logic [CfgW-1:0] step_w,
                                logic [CfgW-1:0] amp_w, logic [CfgW-1:0] duty_w);
    wait_drained();
    write_reg(CFG_WAVE_SEL, sel_w);
    write_reg(CFG_PHASE_STEP, step_w);
    write_reg(CFG_AMPLITUDE, amp_w);
    write_reg(CFG_PULSE_DUTY, duty_w);
    cfg_we_i <= 1'b0;
  endtask

  // Every result beat is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && strobe) begin
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("sample %0d with none expected", sample_value_o));
      end else begin
        due_sample = expected_samples.pop_front();
        if (sample_value_o !== due_sample) begin
          report_mismatch($sformatf("sample_value %0d, expected %0d", sample_value_o,
                                    due_sample));
        end
      end
    end
  end

  // Main sequence: reset, the directed table, then random phases of settings and indices.
  initial begin
    logic [63:0]     ang;
    logic [63:0]     ang2;
    logic [63:0]     term;
    longint          acc;
    longint          rounded;
    int unsigned     n;
    int unsigned     pick;
    int unsigned     phase_len;
    int unsigned     idx_mode;
    int unsigned     random_sent;
    logic [CfgW-1:0] sel_w;
    logic [CfgW-1:0] step_w;
    logic [CfgW-1:0] amp_w;
    logic [CfgW-1:0] duty_w;
    logic [IndexW-1:0] base;

    // Quarter-wave cosine in Q16 from a nine-term Taylor series in Q30.
    for (int unsigned k = 0; k <= TabN; k++) begin
      ang  = (64'(k) * HalfPiQ30) >> TabBits;
      ang2 = (ang * ang) >> 30;
      term = 64'd1 << 30;
      acc  = longint'(term);
      for (n = 1; n <= 8; n++) begin
        term = ((term * ang2) >> 30) / 64'((2 * n - 1) * (2 * n));
        acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) begin
        cos_mag[k] = '0;
      end else begin
        rounded    = (acc + 8192) >>> 14;
        cos_mag[k] = (rounded > 65536) ? CosW'(65536) : CosW'(rounded);
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows; settings are rewritten only where a row changes them.
    foreach (dir_rows[r]) begin
      if (dir_rows[r].sel[SelW-1:0] != wave_r || dir_rows[r].step != step_r ||
          dir_rows[r].amp[AmpW-1:0] != amp_r || dir_rows[r].duty[DutyW-1:0] != duty_r) begin
        apply_settings(dir_rows[r].sel, dir_rows[r].step, dir_rows[r].amp, dir_rows[r].duty);
      end
      send_index(dir_rows[r].index, dir_rows[r].known, dir_rows[r].value);
    end

    // Random phases, each with its own settings, index pattern and idling.
    random_sent = 0;
    while (random_sent < RandomBeats) begin
      pick  = $urandom_range(0, 9);
      sel_w = ($urandom() & ~32'h7) |
              ((pick < 8) ? 32'(wave_e'(pick % 5)) : 32'($urandom_range(5, 7)));
      case ($urandom_range(0, 5))
        0:       step_w = '0;
        1:       step_w = '1;
        2:       step_w = 32'h1;
        3:       step_w = StepRst;
        4:       step_w = $urandom_range(1, 1 << 20);
        default: step_w = $urandom();
      endcase
      case ($urandom_range(0, 4))
        0:       amp_w = '0;
        1:       amp_w = 32'h7FFF;
        2:       amp_w = '1;
        default: amp_w = $urandom();
      endcase
      case ($urandom_range(0, 4))
        0:       duty_w = '0;
        1:       duty_w = 32'hFFFF;
        2:       duty_w = {16'($urandom_range(0, 65535)), 16'h8000};
        default: duty_w = $urandom();
      endcase
      apply_settings(sel_w, step_w, amp_w, duty_w);

      gapless   = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 60);
      idx_mode  = $urandom_range(0, 2);
      base      = (idx_mode == 2) ? 32'hFFFF_FFFF - $urandom_range(0, 30) : $urandom();
      for (int unsigned k = 0; k < phase_len; k++) begin
        send_index((idx_mode == 1) ? $urandom() : base + k, 1'b0, '0);
        random_sent++;
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin
    #(2_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
